// ===== rtl/regex_followpos_builder_core_assert.svh =====
// Assertion macros for the followpos builder checker.
// Needs clk and rst_n in the scope of each use.
`ifndef REGEX_FOLLOWPOS_BUILDER_CORE_ASSERT_SVH
`define REGEX_FOLLOWPOS_BUILDER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfb_pkg.sv =====
// Shared types and constants of the followpos builder.
// No dependencies; rfb_if, rfb_follow, the top level and the checker refer to it by scoped names.
`default_nettype none

package rfb_pkg;

  localparam int unsigned TYPE_W    = 2;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned POS_OUT_W = 5;
  localparam int unsigned SET_OUT_W = 16;
  localparam int unsigned ERR_W     = 3;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LEAF = 2'd0,
    REQ_ALT  = 2'd1,
    REQ_CAT  = 2'd2,
    REQ_STAR = 2'd3
  } rfb_req_t;

  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_END   = 3'd4;

  // Sequencer to row-update unit
  typedef struct packed {
    logic start;
    logic clear;
  } rfb_fol_ctl_t;

  // Row-update unit to sequencer
  typedef struct packed {
    logic busy;
  } rfb_fol_sts_t;

endpackage

`default_nettype wire

// ===== rtl/rfb_if.sv =====
// Valid/ready channel interfaces for symbol input and row output.
// Depends on rfb_pkg for field widths.
`default_nettype none

interface rfb_in_if;
  logic                       valid;
  logic                       ready;
  logic [rfb_pkg::TYPE_W-1:0] req_type;
  logic [rfb_pkg::SYM_W-1:0]  symbol_char;
  logic                       end_of_expression;

  modport source (output valid, req_type, symbol_char, end_of_expression, input ready);
  modport sink   (input valid, req_type, symbol_char, end_of_expression, output ready);
endinterface

interface rfb_out_if;
  logic                          valid;
  logic                          ready;
  logic [rfb_pkg::POS_OUT_W-1:0] position;
  logic [rfb_pkg::SYM_W-1:0]     position_symbol;
  logic [rfb_pkg::SET_OUT_W-1:0] follow_set;
  logic                          root_nullable;
  logic [rfb_pkg::SET_OUT_W-1:0] root_firstpos;
  logic [rfb_pkg::SET_OUT_W-1:0] root_lastpos;
  logic [rfb_pkg::ERR_W-1:0]     error_code;
  logic                          last_row;

  modport source (output valid, position, position_symbol, follow_set, root_nullable,
                  root_firstpos, root_lastpos, error_code, last_row, input ready);
  modport sink   (input valid, position, position_symbol, follow_set, root_nullable,
                  root_firstpos, root_lastpos, error_code, last_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/rfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rfb_follow.sv =====
// Followpos table and its row-update unit: scans all rows, one per cycle,
// and ORs a set into each row selected by a source set. Uses rfb_pkg, rfb_ram.
`default_nettype none

module rfb_follow #(
  parameter int unsigned MAX_POSITIONS = 16,
  localparam int unsigned KW = $clog2(MAX_POSITIONS)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rfb_pkg::rfb_fol_ctl_t           ctl,
  input  wire logic [MAX_POSITIONS-1:0]        from_set,
  input  wire logic [MAX_POSITIONS-1:0]        add_set,
  input  wire logic [KW-1:0]                   rd_addr,
  output logic      [rfb_pkg::SET_OUT_W-1:0]   rd_row,
  output rfb_pkg::rfb_fol_sts_t                sts
);

  localparam int unsigned MP = MAX_POSITIONS;

  logic          active_r, active_nxt;
  logic [KW-1:0] scan_k_r, scan_k_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic          pend_en_r, pend_en_nxt;
  logic [KW-1:0] pend_k_r, pend_k_nxt;
  logic [MP-1:0] from_r, from_nxt;
  logic [MP-1:0] add_r, add_nxt;
  logic [MP-1:0] row_vld_r, row_vld_nxt;
  logic          rd_vld_r, rd_vld_nxt;

  logic          ram_we;
  logic [KW-1:0] ram_raddr;
  logic [MP-1:0] ram_wdata;
  logic [MP-1:0] ram_rdata;
  logic [MP+rfb_pkg::SET_OUT_W-1:0] row_wide;

  rfb_ram #(.WIDTH(MP), .DEPTH(MP)) u_rows (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (pend_k_r),
    .wdata  (ram_wdata),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  assign ram_raddr = active_r ? scan_k_r : rd_addr;
  assign ram_we    = pend_vld_r & pend_en_r;
  // A row never written since the last clear reads as empty
  assign ram_wdata = (row_vld_r[pend_k_r] ? ram_rdata : '0) | add_r;

  always_comb begin
    active_nxt   = active_r;
    scan_k_nxt   = scan_k_r;
    from_nxt     = from_r;
    add_nxt      = add_r;
    row_vld_nxt  = row_vld_r;
    pend_vld_nxt = active_r;
    pend_en_nxt  = from_r[scan_k_r];
    pend_k_nxt   = scan_k_r;
    rd_vld_nxt   = row_vld_r[rd_addr];

    if (ctl.start) begin
      active_nxt = 1'b1;
      scan_k_nxt = '0;
      from_nxt   = from_set;
      add_nxt    = add_set;
    end else if (active_r) begin
      scan_k_nxt = scan_k_r + KW'(1);
      if (scan_k_r == KW'(MP - 1)) begin
        active_nxt = 1'b0;
      end
    end

    if (ctl.clear) begin
      row_vld_nxt = '0;
    end else if (ram_we) begin
      row_vld_nxt[pend_k_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      row_vld_r  <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      pend_vld_r <= pend_vld_nxt;
      row_vld_r  <= row_vld_nxt;
      rd_vld_r   <= rd_vld_nxt;
    end
    scan_k_r  <= scan_k_nxt;
    pend_en_r <= pend_en_nxt;
    pend_k_r  <= pend_k_nxt;
    from_r    <= from_nxt;
    add_r     <= add_nxt;
  end

  assign row_wide = {{rfb_pkg::SET_OUT_W{1'b0}}, (rd_vld_r ? ram_rdata : '0)};
  assign rd_row   = row_wide[rfb_pkg::SET_OUT_W-1:0];
  assign sts.busy = active_r | pend_vld_r;

endmodule

`default_nettype wire

// ===== rtl/regex_followpos_builder_core.sv =====
// Followpos builder top level: postfix symbol sequencer, operand stack and
// output rows. Uses rfb_pkg, rfb_if, rfb_ram and rfb_follow.
//
//   channel  dir  transfer carries
//   in_ch    in   one postfix symbol: req_type, symbol_char, end_of_expression
//   out_ch   out  one followpos row per position (single row when none)
//
// Leaf: S_LEAF, S_END. Alternation: S_TOP, S_SEC, S_END. Star: S_TOP, S_UPD,
// S_END; concatenation: S_TOP, S_SEC, S_UPD, S_END; the row-update unit walks
// every followpos row once, one row per cycle. Underflowed operator: S_END.
// End symbol: S_ROOT, then S_ROW_RD/LD/OUT per row, plus output stalls.
// rst_n is synchronous; the followpos table clears through per-row valid bits,
// so no clearing pass is needed. in_ch.ready is low while an item is worked on.
`default_nettype none

module regex_followpos_builder_core #(
  parameter int unsigned MAX_POSITIONS = 16,
  parameter int unsigned STACK_DEPTH   = 16
) (
  input wire logic    clk,
  input wire logic    rst_n,
  rfb_in_if.sink      in_ch,
  rfb_out_if.source   out_ch
);

  localparam int unsigned MP  = MAX_POSITIONS;
  localparam int unsigned SD  = STACK_DEPTH;
  localparam int unsigned EW  = 2 * MP + 1;
  localparam int unsigned KW  = $clog2(MP);
  localparam int unsigned PW  = $clog2(MP + 2);
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned DW  = $clog2(SD + 1);
  localparam int unsigned OW  = rfb_pkg::SET_OUT_W;
  localparam int unsigned PO  = rfb_pkg::POS_OUT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LEAF, S_TOP, S_SEC, S_UPD, S_END, S_ROOT, S_ROW_RD, S_ROW_LD, S_ROW_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  rfb_pkg::rfb_req_t          type_r, type_nxt;
  logic [rfb_pkg::SYM_W-1:0]  sym_r, sym_nxt;
  logic                       end_r, end_nxt;
  logic [DW-1:0]              depth_r, depth_nxt;
  logic [PW-1:0]              np_r, np_nxt;
  logic [rfb_pkg::ERR_W-1:0]  err_r, err_nxt;
  logic [EW-1:0]              top_r, top_nxt;
  logic [EW-1:0]              root_r, root_nxt;
  logic [KW-1:0]              row_k_r, row_k_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [PO-1:0]              out_pos_r, out_pos_nxt;
  logic [rfb_pkg::SYM_W-1:0]  out_sym_r, out_sym_nxt;
  logic [OW-1:0]              out_fol_r, out_fol_nxt;
  logic                       out_null_r, out_null_nxt;
  logic [OW-1:0]              out_first_r, out_first_nxt;
  logic [OW-1:0]              out_lastp_r, out_lastp_nxt;
  logic [rfb_pkg::ERR_W-1:0]  out_err_r, out_err_nxt;
  logic                       out_last_row_r, out_last_row_nxt;

  logic                       stk_we;
  logic [SAW-1:0]             stk_waddr;
  logic [EW-1:0]              stk_wdata;
  logic [SAW-1:0]             stk_raddr;
  logic [EW-1:0]              stk_rdata;
  logic                       leaf_we;
  logic [KW-1:0]              leaf_waddr;
  logic [rfb_pkg::SYM_W-1:0]  leaf_rdata;

  rfb_pkg::rfb_fol_ctl_t      fol_ctl;
  rfb_pkg::rfb_fol_sts_t      fol_sts;
  logic [MP-1:0]              fol_from;
  logic [MP-1:0]              fol_add;
  logic [OW-1:0]              fol_row;

  logic [DW-1:0]              depth_m1;
  logic [DW-1:0]              depth_m2;
  logic [PW-1:0]              np_m1;
  logic [PW-1:0]              row_k_p1;
  logic [PW+PO-1:0]           pos_wide;
  logic [MP+OW-1:0]           first_wide;
  logic [MP+OW-1:0]           last_wide;
  logic [MP-1:0]              leaf_set;
  logic                       in_xfer;
  logic                       row_is_last;
  logic [rfb_pkg::ERR_W-1:0]  err_tmp;

  // Entry layout: {nullable, firstpos, lastpos}
  logic                       r_n, l_n;
  logic [MP-1:0]              r_f, r_l, l_f, l_l;

  function automatic logic [rfb_pkg::ERR_W-1:0] keep_first(
    input logic [rfb_pkg::ERR_W-1:0] cur,
    input logic [rfb_pkg::ERR_W-1:0] code
  );
    return (cur == rfb_pkg::ERR_NONE) ? code : cur;
  endfunction

  rfb_ram #(.WIDTH(EW), .DEPTH(SD)) u_stack (
    .clk    (clk),
    .we     (stk_we),
    .waddr  (stk_waddr),
    .wdata  (stk_wdata),
    .raddr  (stk_raddr),
    .rdata_r(stk_rdata)
  );

  rfb_ram #(.WIDTH(rfb_pkg::SYM_W), .DEPTH(MP)) u_leaf (
    .clk    (clk),
    .we     (leaf_we),
    .waddr  (leaf_waddr),
    .wdata  (sym_r),
    .raddr  (row_k_r),
    .rdata_r(leaf_rdata)
  );

  rfb_follow #(.MAX_POSITIONS(MP)) u_follow (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fol_ctl),
    .from_set(fol_from),
    .add_set (fol_add),
    .rd_addr (row_k_r),
    .rd_row  (fol_row),
    .sts     (fol_sts)
  );

  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign depth_m1    = depth_r - DW'(1);
  assign depth_m2    = depth_r - DW'(2);
  assign np_m1       = np_r - PW'(1);
  assign row_k_p1    = PW'(row_k_r) + PW'(1);
  assign pos_wide    = {{PO{1'b0}}, row_k_p1};
  assign first_wide  = {{OW{1'b0}}, root_r[2*MP-1:MP]};
  assign last_wide   = {{OW{1'b0}}, root_r[MP-1:0]};
  assign leaf_set    = {{(MP-1){1'b0}}, 1'b1} << np_m1[KW-1:0];
  assign row_is_last = (np_m1 == '0) || (row_k_p1 == np_m1);
  // The second operand is read while the top one arrives
  assign stk_raddr   = (state_r == S_TOP) ? depth_m2[SAW-1:0] : depth_m1[SAW-1:0];
  assign leaf_waddr  = np_m1[KW-1:0];

  assign r_n = top_r[EW-1];
  assign r_f = top_r[2*MP-1:MP];
  assign r_l = top_r[MP-1:0];
  assign l_n = stk_rdata[EW-1];
  assign l_f = stk_rdata[2*MP-1:MP];
  assign l_l = stk_rdata[MP-1:0];

  always_comb begin
    state_nxt        = state_r;
    type_nxt         = type_r;
    sym_nxt          = sym_r;
    end_nxt          = end_r;
    depth_nxt        = depth_r;
    np_nxt           = np_r;
    err_nxt          = err_r;
    top_nxt          = top_r;
    root_nxt         = root_r;
    row_k_nxt        = row_k_r;
    out_valid_nxt    = out_valid_r;
    out_pos_nxt      = out_pos_r;
    out_sym_nxt      = out_sym_r;
    out_fol_nxt      = out_fol_r;
    out_null_nxt     = out_null_r;
    out_first_nxt    = out_first_r;
    out_lastp_nxt    = out_lastp_r;
    out_err_nxt      = out_err_r;
    out_last_row_nxt = out_last_row_r;
    stk_we           = 1'b0;
    stk_waddr        = depth_m1[SAW-1:0];
    stk_wdata        = '0;
    leaf_we          = 1'b0;
    fol_ctl          = '0;
    fol_from         = '0;
    fol_add          = '0;
    err_tmp          = err_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          type_nxt = rfb_pkg::rfb_req_t'(in_ch.req_type);
          sym_nxt  = in_ch.symbol_char;
          end_nxt  = in_ch.end_of_expression;
          case (rfb_pkg::rfb_req_t'(in_ch.req_type))
            rfb_pkg::REQ_LEAF: begin
              state_nxt = S_LEAF;
            end
            rfb_pkg::REQ_STAR: begin
              if (depth_r < DW'(1)) begin
                err_nxt   = keep_first(err_r, rfb_pkg::ERR_UNDERFLOW);
                state_nxt = S_END;
              end else begin
                state_nxt = S_TOP;
              end
            end
            default: begin
              if (depth_r < DW'(2)) begin
                err_nxt   = keep_first(err_r, rfb_pkg::ERR_UNDERFLOW);
                state_nxt = S_END;
              end else begin
                state_nxt = S_TOP;
              end
            end
          endcase
        end
      end

      S_LEAF: begin
        stk_waddr = depth_r[SAW-1:0];
        if (np_r <= PW'(MP)) begin
          leaf_we   = 1'b1;
          np_nxt    = np_r + PW'(1);
          stk_wdata = {1'b0, leaf_set, leaf_set};
        end else begin
          err_tmp   = keep_first(err_tmp, rfb_pkg::ERR_TOO_MANY);
        end
        if (depth_r >= DW'(SD)) begin
          err_tmp = keep_first(err_tmp, rfb_pkg::ERR_OVERFLOW);
        end else begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + DW'(1);
        end
        err_nxt   = err_tmp;
        state_nxt = S_END;
      end

      S_TOP: begin
        top_nxt = stk_rdata;
        if (type_r == rfb_pkg::REQ_STAR) begin
          stk_we      = 1'b1;
          stk_wdata   = {1'b1, stk_rdata[2*MP-1:0]};
          fol_ctl.start = 1'b1;
          fol_from    = stk_rdata[MP-1:0];
          fol_add     = stk_rdata[2*MP-1:MP];
          state_nxt   = S_UPD;
        end else begin
          state_nxt = S_SEC;
        end
      end

      S_SEC: begin
        stk_waddr = depth_m2[SAW-1:0];
        stk_we    = 1'b1;
        depth_nxt = depth_m1;
        if (type_r == rfb_pkg::REQ_ALT) begin
          stk_wdata = {l_n | r_n, l_f | r_f, l_l | r_l};
          state_nxt = S_END;
        end else begin
          stk_wdata = {l_n & r_n, (l_n ? (l_f | r_f) : l_f), (r_n ? (l_l | r_l) : r_l)};
          fol_ctl.start = 1'b1;
          fol_from  = l_l;
          fol_add   = r_f;
          state_nxt = S_UPD;
        end
      end

      S_UPD: begin
        if (!fol_sts.busy) begin
          state_nxt = S_END;
        end
      end

      S_END: begin
        if (!end_r) begin
          state_nxt = S_IDLE;
        end else begin
          if (depth_r != DW'(1)) begin
            err_nxt = keep_first(err_r, rfb_pkg::ERR_BAD_END);
          end
          state_nxt = S_ROOT;
        end
      end

      S_ROOT: begin
        root_nxt  = (depth_r != '0) ? stk_rdata : '0;
        row_k_nxt = '0;
        state_nxt = S_ROW_RD;
      end

      S_ROW_RD: begin
        state_nxt = S_ROW_LD;
      end

      S_ROW_LD: begin
        if (np_m1 == '0) begin
          out_pos_nxt = '0;
          out_sym_nxt = '0;
          out_fol_nxt = '0;
        end else begin
          out_pos_nxt = pos_wide[PO-1:0];
          out_sym_nxt = leaf_rdata;
          out_fol_nxt = fol_row;
        end
        out_null_nxt     = root_r[EW-1];
        out_first_nxt    = first_wide[OW-1:0];
        out_lastp_nxt    = last_wide[OW-1:0];
        out_err_nxt      = err_r;
        out_last_row_nxt = row_is_last;
        out_valid_nxt    = 1'b1;
        state_nxt        = S_ROW_OUT;
      end

      S_ROW_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_row_r) begin
            // Drop the whole expression state for the next one
            depth_nxt     = '0;
            np_nxt        = PW'(1);
            err_nxt       = rfb_pkg::ERR_NONE;
            fol_ctl.clear = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            row_k_nxt = row_k_r + KW'(1);
            state_nxt = S_ROW_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      np_r        <= PW'(1);
      err_r       <= rfb_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      np_r        <= np_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r         <= type_nxt;
    sym_r          <= sym_nxt;
    end_r          <= end_nxt;
    top_r          <= top_nxt;
    root_r         <= root_nxt;
    row_k_r        <= row_k_nxt;
    out_pos_r      <= out_pos_nxt;
    out_sym_r      <= out_sym_nxt;
    out_fol_r      <= out_fol_nxt;
    out_null_r     <= out_null_nxt;
    out_first_r    <= out_first_nxt;
    out_lastp_r    <= out_lastp_nxt;
    out_err_r      <= out_err_nxt;
    out_last_row_r <= out_last_row_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.position        = out_pos_r;
  assign out_ch.position_symbol = out_sym_r;
  assign out_ch.follow_set      = out_fol_r;
  assign out_ch.root_nullable   = out_null_r;
  assign out_ch.root_firstpos   = out_first_r;
  assign out_ch.root_lastpos    = out_lastp_r;
  assign out_ch.error_code      = out_err_r;
  assign out_ch.last_row        = out_last_row_r;

endmodule

`default_nettype wire

// ===== rtl/rfb_checker.sv =====
// Port-level checks of the followpos builder, bound to its top level.
// Uses rfb_pkg, rfb_if and regex_followpos_builder_core_assert.svh.
`default_nettype none

`include "regex_followpos_builder_core_assert.svh"

module rfb_checker (
  input wire logic  clk,
  input wire logic  rst_n,
  rfb_in_if.sink    in_ch,
  rfb_out_if.source out_ch
);

  `RFB_ASSERT_IMP(a_no_accept_while_emit, out_ch.valid, !in_ch.ready, "input ready while a row is pending")

  `RFB_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready did not drop after a symbol transfer")

  `RFB_ASSERT_IMP(a_empty_row_is_last, out_ch.valid && (out_ch.position == '0), out_ch.last_row, "row without a position is not the last row")

  `RFB_ASSERT_NXT(a_row_held, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.follow_set) && $stable(out_ch.position), "stalled row changed")

  `RFB_ASSERT_IMP(a_err_range, out_ch.valid, out_ch.error_code <= rfb_pkg::ERR_BAD_END, "error code out of range")

endmodule

bind regex_followpos_builder_core rfb_checker u_rfb_checker (
  .clk   (clk),
  .rst_n (rst_n),
  .in_ch (in_ch),
  .out_ch(out_ch)
);

`default_nettype wire
